// ===== rtl/rpc_pkg.sv =====
`default_nettype none

package rpc_pkg;

  // Field widths
  localparam int POS_W  = 24;
  localparam int ANG_W  = 16;
  localparam int DIFF_W = POS_W + 1;

  // Angle units: Q9.6 degrees
  localparam int FULL_TURN    = 23040;
  localparam int HALF_TURN    = FULL_TURN / 2;
  localparam int QUARTER_TURN = FULL_TURN / 4;

  // Reduced angle width: covers +-QUARTER_TURN
  localparam int RED_W = 14;
  // Turn counter width: covers [0, FULL_TURN)
  localparam int TURN_W = 15;

  // CORDIC datapath
  localparam int GAIN_SHIFT = 30;
  localparam int ANGLE_UPSCALE_SHIFT = 16;
  localparam int XW = DIFF_W + GAIN_SHIFT + 2;
  localparam int ZW = 31;
  localparam int ATAN_ENTRIES = 24;
  localparam logic signed [XW-1:0] GAIN_INV_Q30 = XW'(652032874);

  localparam int RES_W = XW - GAIN_SHIFT;
  localparam int SUM_W = RES_W + 1;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // atan(2^-i) in degrees, Q.22
  localparam logic signed [ZW-1:0] ATAN_DEG_Q22 [ATAN_ENTRIES] = '{
    ZW'(188743680), ZW'(111421900), ZW'(58872272), ZW'(29884485),
    ZW'(15000234),  ZW'(7507429),   ZW'(3754631),  ZW'(1877430),
    ZW'(938729),    ZW'(469366),    ZW'(234683),   ZW'(117342),
    ZW'(58671),     ZW'(29335),     ZW'(14668),    ZW'(7334),
    ZW'(3667),      ZW'(1833),      ZW'(917),      ZW'(458),
    ZW'(229),       ZW'(115),       ZW'(57),       ZW'(29)
  };

  // Word handed from cell to cell
  typedef struct packed {
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic signed [ZW-1:0]    z;
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
  } rpc_rot_t;

endpackage

`default_nettype wire

// ===== rtl/rpc_prep.sv =====
`default_nettype none

module rpc_prep
  import rpc_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    vld_i,
  input  wire logic signed [POS_W-1:0] center_x_i,
  input  wire logic signed [POS_W-1:0] center_y_i,
  input  wire logic signed [POS_W-1:0] point_x_i,
  input  wire logic signed [POS_W-1:0] point_y_i,
  input  wire logic signed [ANG_W-1:0] delta_degrees_i,
  output logic                         vld_o,
  output rpc_rot_t                     rot_o
);

  localparam int AE_W = ANG_W + 2;

  // Stage A: offset and angle modulo a full turn
  logic                     vld_a_q;
  logic signed [DIFF_W-1:0] dx_a_q, dy_a_q, dx_a_d, dy_a_d;
  logic        [TURN_W-1:0] r_a_q, r_a_d;
  logic signed [POS_W-1:0]  cx_a_q, cy_a_q;
  logic signed [AE_W-1:0]   a_ext;

  // Stage B: fold into a quarter turn
  logic                     vld_b_q;
  logic signed [DIFF_W-1:0] dx_b_q, dy_b_q, dx_b_d, dy_b_d;
  logic signed [RED_W-1:0]  a_b_q, a_b_d;
  logic signed [POS_W-1:0]  cx_b_q, cy_b_q;
  logic signed [TURN_W:0]   r_s;
  logic                     neg_b;

  // Stage C: gain compensation
  logic     vld_c_q;
  rpc_rot_t rot_c_q, rot_c_d;

  always_comb begin
    a_ext  = AE_W'(delta_degrees_i);
    dx_a_d = DIFF_W'(point_x_i) - DIFF_W'(center_x_i);
    dy_a_d = DIFF_W'(point_y_i) - DIFF_W'(center_y_i);
    if (a_ext < -AE_W'(FULL_TURN)) begin
      r_a_d = TURN_W'(a_ext + AE_W'(2 * FULL_TURN));
    end else if (a_ext < AE_W'(0)) begin
      r_a_d = TURN_W'(a_ext + AE_W'(FULL_TURN));
    end else if (a_ext >= AE_W'(FULL_TURN)) begin
      r_a_d = TURN_W'(a_ext - AE_W'(FULL_TURN));
    end else begin
      r_a_d = TURN_W'(a_ext);
    end
  end

  always_comb begin
    r_s   = signed'({1'b0, r_a_q});
    neg_b = 1'b0;
    if (r_s <= (TURN_W+1)'(QUARTER_TURN)) begin
      a_b_d = RED_W'(r_s);
    end else if (r_s < (TURN_W+1)'(HALF_TURN + QUARTER_TURN)) begin
      a_b_d = RED_W'(r_s - (TURN_W+1)'(HALF_TURN));
      neg_b = 1'b1;
    end else begin
      a_b_d = RED_W'(r_s - (TURN_W+1)'(FULL_TURN));
    end
    dx_b_d = neg_b ? -dx_a_q : dx_a_q;
    dy_b_d = neg_b ? -dy_a_q : dy_a_q;
  end

  always_comb begin
    rot_c_d.x  = XW'(dx_b_q) * GAIN_INV_Q30;
    rot_c_d.y  = XW'(dy_b_q) * GAIN_INV_Q30;
    rot_c_d.z  = ZW'(a_b_q) <<< ANGLE_UPSCALE_SHIFT;
    rot_c_d.cx = cx_b_q;
    rot_c_d.cy = cy_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_a_q  <= dx_a_d;
      dy_a_q  <= dy_a_d;
      r_a_q   <= r_a_d;
      cx_a_q  <= center_x_i;
      cy_a_q  <= center_y_i;
      dx_b_q  <= dx_b_d;
      dy_b_q  <= dy_b_d;
      a_b_q   <= a_b_d;
      cx_b_q  <= cx_a_q;
      cy_b_q  <= cy_a_q;
      rot_c_q <= rot_c_d;
    end
  end

  assign vld_o = vld_c_q;
  assign rot_o = rot_c_q;

  a_turn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_a_q |-> (r_a_q < TURN_W'(FULL_TURN)))
    else $error("angle not reduced into one turn");

  a_quarter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_b_q |-> (a_b_q <= RED_W'(QUARTER_TURN)) && (a_b_q >= -RED_W'(QUARTER_TURN)))
    else $error("folded angle outside a quarter turn");

endmodule

`default_nettype wire

// ===== rtl/rpc_cell.sv =====
`default_nettype none

module rpc_cell
  import rpc_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic vld_i,
  input  rpc_rot_t  rot_i,
  output logic      vld_o,
  output rpc_rot_t  rot_o
);

  logic signed [XW-1:0] xs, ys;
  logic                 vld_q;
  rpc_rot_t             rot_q, rot_d;

  always_comb begin
    xs    = rot_i.x >>> Idx;
    ys    = rot_i.y >>> Idx;
    rot_d = rot_i;
    // steer toward zero residual angle
    if (rot_i.z >= ZW'(0)) begin
      rot_d.x = rot_i.x - ys;
      rot_d.y = rot_i.y + xs;
      rot_d.z = rot_i.z - ATAN_DEG_Q22[Idx];
    end else begin
      rot_d.x = rot_i.x + ys;
      rot_d.y = rot_i.y - xs;
      rot_d.z = rot_i.z + ATAN_DEG_Q22[Idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign vld_o = vld_q;
  assign rot_o = rot_q;

  a_resid_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (rot_q.z < (ZW'(1) <<< 29)) && (rot_q.z > -(ZW'(1) <<< 29)))
    else $error("residual angle diverged");

endmodule

`default_nettype wire

// ===== rtl/rpc_post.sv =====
`default_nettype none

module rpc_post
  import rpc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               vld_i,
  input  rpc_rot_t                rot_i,
  output logic                    out_valid_o,
  output logic signed [POS_W-1:0] rotated_x_o,
  output logic signed [POS_W-1:0] rotated_y_o,
  output logic                    saturated_o
);

  logic signed [XW-1:0]    xr, yr;
  logic signed [SUM_W-1:0] sx, sy;
  logic signed [POS_W-1:0] rx_d, ry_d, rx_q, ry_q;
  logic                    satx, saty, sat_q, vld_q;

  always_comb begin
    // round half up back to the position grid, then restore the center
    xr = rot_i.x + (XW'(1) <<< (GAIN_SHIFT - 1));
    yr = rot_i.y + (XW'(1) <<< (GAIN_SHIFT - 1));
    sx = SUM_W'(signed'(xr[XW-1:GAIN_SHIFT])) + SUM_W'(rot_i.cx);
    sy = SUM_W'(signed'(yr[XW-1:GAIN_SHIFT])) + SUM_W'(rot_i.cy);
    satx = 1'b1;
    saty = 1'b1;
    if (sx > SUM_W'(POS_MAX)) begin
      rx_d = POS_MAX;
    end else if (sx < SUM_W'(POS_MIN)) begin
      rx_d = POS_MIN;
    end else begin
      rx_d = POS_W'(sx);
      satx = 1'b0;
    end
    if (sy > SUM_W'(POS_MAX)) begin
      ry_d = POS_MAX;
    end else if (sy < SUM_W'(POS_MIN)) begin
      ry_d = POS_MIN;
    end else begin
      ry_d = POS_W'(sy);
      saty = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      sat_q <= satx | saty;
    end
  end

  assign out_valid_o = vld_q;
  assign rotated_x_o = rx_q;
  assign rotated_y_o = ry_q;
  assign saturated_o = sat_q;

  a_sat_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && sat_q) |-> (rx_q == POS_MAX) || (rx_q == POS_MIN)
                         || (ry_q == POS_MAX) || (ry_q == POS_MIN))
    else $error("saturation flag without a clamped coordinate");

endmodule

`default_nettype wire

// ===== rtl/rotate_point_about_center_unit.sv =====
`default_nettype none

// Rotates a point about a center by an angle in Q9.6 degrees (counterclockwise
// positive) and returns the absolute position in Q16.8, clamped to 24 bits with
// a saturation flag. Any 16-bit angle is accepted and reduced modulo a full
// turn. One word is accepted per cycle unless the output is stalled. The
// pipeline is three front stages (offset and angle reduction, quarter-turn
// fold, gain multiply), one CORDIC cell per stage, and the round/clamp output
// register. The whole pipeline holds while a finished word waits at the output.

module rotate_point_about_center_unit
  import rpc_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic signed [POS_W-1:0] center_x_i,
  input  wire logic signed [POS_W-1:0] center_y_i,
  input  wire logic signed [POS_W-1:0] point_x_i,
  input  wire logic signed [POS_W-1:0] point_y_i,
  input  wire logic signed [ANG_W-1:0] delta_degrees_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [POS_W-1:0]      rotated_x_o,
  output logic signed [POS_W-1:0]      rotated_y_o,
  output logic                         saturated_o
);

  localparam int unsigned NumCells =
    (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

  logic     en;
  logic     vld  [NumCells+1];
  rpc_rot_t rot  [NumCells+1];

  // advance unless a finished word is stuck at the output
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  rpc_prep u_prep (
    .clk_i,
    .rst_ni,
    .en_i            (en),
    .vld_i           (in_valid_i),
    .center_x_i,
    .center_y_i,
    .point_x_i,
    .point_y_i,
    .delta_degrees_i,
    .vld_o           (vld[0]),
    .rot_o           (rot[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rpc_cell #(
      .Idx(i)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .en_i  (en),
      .vld_i (vld[i]),
      .rot_i (rot[i]),
      .vld_o (vld[i+1]),
      .rot_o (rot[i+1])
    );
  end

  rpc_post u_post (
    .clk_i,
    .rst_ni,
    .en_i        (en),
    .vld_i       (vld[NumCells]),
    .rot_i       (rot[NumCells]),
    .out_valid_o,
    .rotated_x_o,
    .rotated_y_o,
    .saturated_o
  );

endmodule

`default_nettype wire
